FILE: rtl/core/pin_block_formatter_macros.svh
// ----------------------------------------------------------------------------
// pin block formatter assertion macros
// Shared concurrent assertion forms for the PIN block formatter RTL.
// ----------------------------------------------------------------------------
`ifndef PIN_BLOCK_FORMATTER_MACROS_SVH
`define PIN_BLOCK_FORMATTER_MACROS_SVH

// same-cycle implication, disabled during reset
`define PBF_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pin block formatter: same-cycle check failed");

// next-cycle implication, disabled during reset
`define PBF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pin block formatter: next-cycle check failed");

`endif

FILE: rtl/core/pbf_pkg.sv
// ----------------------------------------------------------------------------
// pbf_pkg
// Field widths, format codes and status codes of the PIN block formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package pbf_pkg;

  // field widths
  localparam int MODE_W     = 3;
  localparam int PIN_W      = 48;
  localparam int PIN_LEN_W  = 4;
  localparam int PAN_HEAD_W = 12;
  localparam int PAN_TAIL_W = 64;
  localparam int PAN_LEN_W  = 5;
  localparam int UID_W      = 56;
  localparam int UID_LEN_W  = 4;
  localparam int WORD_W     = 64;
  localparam int WIDX_W     = 2;

  // format codes
  localparam logic [MODE_W-1:0] FMT_0 = 3'd0;
  localparam logic [MODE_W-1:0] FMT_1 = 3'd1;
  localparam logic [MODE_W-1:0] FMT_2 = 3'd2;
  localparam logic [MODE_W-1:0] FMT_3 = 3'd3;
  localparam logic [MODE_W-1:0] FMT_4 = 3'd4;

  // status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // index of the final word of a request
  localparam logic [WIDX_W-1:0] LAST_IDX_SINGLE = 2'd0;
  localparam logic [WIDX_W-1:0] LAST_IDX_FMT4   = 2'd3;

  // nibble constants
  localparam logic [3:0] NIB_FILL_F = 4'hF;
  localparam logic [3:0] NIB_FILL_A = 4'hA;

  // PAN length window and PIN field size
  localparam logic [PAN_LEN_W-1:0] PAN_LEN_MIN     = 5'd13;
  localparam logic [PAN_LEN_W-1:0] PAN_LEN_MAX     = 5'd19;
  localparam logic [PAN_LEN_W-1:0] PAN_RIGHT_DIGITS = 5'd12;
  localparam logic [PIN_LEN_W-1:0] PIN_FIELD_DIGITS = 4'd12;
  localparam logic [PIN_LEN_W-1:0] PIN_UID_ROOM     = 4'd14;

  // one request as held in the input register
  typedef struct packed {
    logic [MODE_W-1:0]     mode;
    logic [PIN_W-1:0]      pin_digits;
    logic [PIN_LEN_W-1:0]  pin_length;
    logic [PAN_HEAD_W-1:0] pan_head;
    logic [PAN_TAIL_W-1:0] pan_tail;
    logic [PAN_LEN_W-1:0]  pan_length;
    logic [UID_W-1:0]      txn_id;
    logic [UID_LEN_W-1:0]  txn_id_length;
    logic [WORD_W-1:0]     random_fill;
  } req_t;

endpackage

`default_nettype wire

FILE: rtl/core/pbf_if.sv
// ----------------------------------------------------------------------------
// pbf_if
// Valid/ready channels of the PIN block formatter: request in, words out.
// ----------------------------------------------------------------------------
`default_nettype none

// request channel
interface pbf_in_if;
  logic                             valid;
  logic                             ready;
  logic [pbf_pkg::MODE_W-1:0]       mode;
  logic [pbf_pkg::PIN_W-1:0]        pin_digits;
  logic [pbf_pkg::PIN_LEN_W-1:0]    pin_length;
  logic [pbf_pkg::PAN_HEAD_W-1:0]   pan_head;
  logic [pbf_pkg::PAN_TAIL_W-1:0]   pan_tail;
  logic [pbf_pkg::PAN_LEN_W-1:0]    pan_length;
  logic [pbf_pkg::UID_W-1:0]        txn_id;
  logic [pbf_pkg::UID_LEN_W-1:0]    txn_id_length;
  logic [pbf_pkg::WORD_W-1:0]       random_fill;

  modport source (
    output valid, mode, pin_digits, pin_length, pan_head, pan_tail, pan_length,
           txn_id, txn_id_length, random_fill,
    input  ready
  );
  modport sink (
    input  valid, mode, pin_digits, pin_length, pan_head, pan_tail, pan_length,
           txn_id, txn_id_length, random_fill,
    output ready
  );
endinterface

// result word channel
interface pbf_out_if;
  logic                          valid;
  logic                          ready;
  logic [pbf_pkg::WORD_W-1:0]    block_word;
  logic [pbf_pkg::WIDX_W-1:0]    word_index;
  logic                          last_word;
  logic                          status;

  modport source (
    output valid, block_word, word_index, last_word, status,
    input  ready
  );
  modport sink (
    input  valid, block_word, word_index, last_word, status,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/pin_block_formatter.sv
// ----------------------------------------------------------------------------
// pin_block_formatter
// Builds a clear ISO 9564 PIN block, formats 0 to 4, from one request. A
// request is captured in an input register, the whole block is formed by
// combinational logic and loaded into a four-word result register, which
// shifts out one word per output transfer. Formats 0 to 3 and rejected
// requests give one word, so a new request can be taken every cycle while
// the output is not stalled; a format 4 request gives four words (PIN field
// high, PIN field low, PAN field high, PAN field low) and holds the result
// register for four transfers, so the request rate is set by the number of
// words drained from the result register. A request passes the input
// register and then the result register before its first word appears. No
// state carries between requests and there is no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module pin_block_formatter #(
  parameter int MAX_PIN_DIGITS = 12
) (
  input  wire       clk,
  input  wire       rst_n,
  pbf_in_if.sink    in_req,
  pbf_out_if.source out_rsp
);

`include "pin_block_formatter_macros.svh"

  localparam logic [pbf_pkg::PIN_LEN_W-1:0] MAX_PIN_LEN = 4'(MAX_PIN_DIGITS);

  // input stage
  logic          s1_valid_r, s1_valid_nxt;
  pbf_pkg::req_t req_r, req_nxt;

  // result stage
  logic [pbf_pkg::WORD_W-1:0] words_r [4];
  logic [pbf_pkg::WORD_W-1:0] words_nxt [4];
  logic                       s2_valid_r, s2_valid_nxt;
  logic [pbf_pkg::WIDX_W-1:0] idx_r, idx_nxt;
  logic [pbf_pkg::WIDX_W-1:0] last_idx_r, last_idx_nxt;
  logic                       status_r, status_nxt;

  // handshake
  logic in_xfer, out_xfer, out_last, s2_free, s1_move;

  // block build
  logic [pbf_pkg::WORD_W-1:0] blk_words [4];
  logic [pbf_pkg::WIDX_W-1:0] blk_last_idx;
  logic                       blk_status;

  // format 3 fill: keep the random nibble in A..F
  function automatic logic [3:0] fmt3_fill(input logic [3:0] r);
    logic [3:0] res;
    if (r < pbf_pkg::NIB_FILL_A) begin
      res = pbf_pkg::NIB_FILL_A + {1'b0, r[3:1]};
    end else begin
      res = r;
    end
    return res;
  endfunction

  // handshake control
  assign out_last = (idx_r == last_idx_r);
  assign out_xfer = s2_valid_r && out_rsp.ready;
  assign s2_free  = !s2_valid_r || (out_xfer && out_last);
  assign s1_move  = s1_valid_r && s2_free;
  assign in_req.ready = !s1_valid_r || s1_move;
  assign in_xfer  = in_req.valid && in_req.ready;

  // input register next value
  always_comb begin
    s1_valid_nxt = in_xfer || (s1_valid_r && !s1_move);
    req_nxt      = req_r;
    if (in_xfer) begin
      req_nxt.mode             = in_req.mode;
      req_nxt.pin_digits       = in_req.pin_digits;
      req_nxt.pin_length       = in_req.pin_length;
      req_nxt.pan_head         = in_req.pan_head;
      req_nxt.pan_tail         = in_req.pan_tail;
      req_nxt.pan_length       = in_req.pan_length;
      req_nxt.txn_id           = in_req.txn_id;
      req_nxt.txn_id_length    = in_req.txn_id_length;
      req_nxt.random_fill      = in_req.random_fill;
    end
  end

  // PIN and PAN field build from the input register
  always_comb begin
    logic                          need_pan, req_ok;
    logic [pbf_pkg::PAN_LEN_W-1:0] pin_end, pos;
    logic [pbf_pkg::UID_LEN_W-1:0] uid_room, uid_k;
    logic [pbf_pkg::WORD_W-1:0]    pin_word, uid_word, rnd_word, pin_field, pan_xor;
    logic [75:0]                   pan_all, pan_shift, pan_masked;
    logic [pbf_pkg::PAN_LEN_W-1:0] pan_start, pan_m;
    logic [127:0]                  pan_field;
    logic [3:0]                    nib, fill;
    logic [pbf_pkg::PAN_LEN_W-1:0] nidx;

    need_pan = (req_r.mode == pbf_pkg::FMT_0) || (req_r.mode == pbf_pkg::FMT_3) ||
               (req_r.mode == pbf_pkg::FMT_4);
    req_ok   = (req_r.mode <= pbf_pkg::FMT_4) && (req_r.pin_length != '0) &&
               (req_r.pin_length <= MAX_PIN_LEN) &&
               (req_r.pin_length <= pbf_pkg::PIN_FIELD_DIGITS) &&
               (!need_pan || ((req_r.pan_length >= pbf_pkg::PAN_LEN_MIN) &&
                              (req_r.pan_length <= pbf_pkg::PAN_LEN_MAX)));

    // nibble boundaries of the PIN field
    pin_end  = 5'd2 + {1'b0, req_r.pin_length};
    uid_room = pbf_pkg::PIN_UID_ROOM - req_r.pin_length;
    uid_k    = (req_r.txn_id_length < uid_room) ? req_r.txn_id_length : uid_room;
    pos      = (req_r.mode == pbf_pkg::FMT_1) ? (pin_end + {1'b0, uid_k}) : pin_end;

    // sources aligned to their place in the field
    pin_word = {8'h00, req_r.pin_digits, 8'h00};
    uid_word = {req_r.txn_id, 8'h00} >> {pin_end, 2'b00};
    rnd_word = req_r.random_fill >> {pos, 2'b00};

    // per-nibble selection of the PIN field
    pin_field = '0;
    for (int i = 0; i < 16; i++) begin
      nidx = 5'(i);
      unique case (req_r.mode)
        pbf_pkg::FMT_0, pbf_pkg::FMT_2: fill = pbf_pkg::NIB_FILL_F;
        pbf_pkg::FMT_1:                 fill = rnd_word[63-4*i -: 4];
        pbf_pkg::FMT_3:                 fill = fmt3_fill(rnd_word[63-4*i -: 4]);
        default:                        fill = pbf_pkg::NIB_FILL_A;
      endcase
      priority if (i == 0) begin
        nib = {1'b0, req_r.mode};
      end else if (i == 1) begin
        nib = req_r.pin_length;
      end else if (nidx < pin_end) begin
        nib = pin_word[63-4*i -: 4];
      end else if (nidx < pos) begin
        nib = uid_word[63-4*i -: 4];
      end else begin
        nib = fill;
      end
      pin_field[63-4*i -: 4] = nib;
    end

    // rightmost twelve PAN digits without the check digit
    pan_all   = {req_r.pan_head, req_r.pan_tail};
    pan_start = req_r.pan_length - pbf_pkg::PAN_LEN_MIN;
    pan_shift = pan_all << {pan_start[2:0], 2'b00};
    pan_xor   = {16'h0000, pan_shift[75:28]};

    // format 4 PAN field: length code, digits, zero pad
    for (int j = 0; j < 19; j++) begin
      pan_masked[75-4*j -: 4] = (5'(j) < req_r.pan_length) ? pan_all[75-4*j -: 4] : 4'h0;
    end
    pan_m     = req_r.pan_length - pbf_pkg::PAN_RIGHT_DIGITS;
    pan_field = {pan_m[3:0], pan_masked, 48'h0};

    // result words
    if (!req_ok) begin
      blk_words[0] = '0;
      blk_words[1] = '0;
      blk_words[2] = '0;
      blk_words[3] = '0;
      blk_last_idx = pbf_pkg::LAST_IDX_SINGLE;
      blk_status   = pbf_pkg::STATUS_ERR;
    end else if (req_r.mode == pbf_pkg::FMT_4) begin
      blk_words[0] = pin_field;
      blk_words[1] = req_r.random_fill;
      blk_words[2] = pan_field[127:64];
      blk_words[3] = pan_field[63:0];
      blk_last_idx = pbf_pkg::LAST_IDX_FMT4;
      blk_status   = pbf_pkg::STATUS_OK;
    end else begin
      blk_words[0] = need_pan ? (pin_field ^ pan_xor) : pin_field;
      blk_words[1] = '0;
      blk_words[2] = '0;
      blk_words[3] = '0;
      blk_last_idx = pbf_pkg::LAST_IDX_SINGLE;
      blk_status   = pbf_pkg::STATUS_OK;
    end
  end

  // result register next value: load a block or shift out one word
  always_comb begin
    words_nxt    = words_r;
    idx_nxt      = idx_r;
    last_idx_nxt = last_idx_r;
    status_nxt   = status_r;
    s2_valid_nxt = s2_valid_r;
    if (s1_move) begin
      words_nxt    = blk_words;
      idx_nxt      = '0;
      last_idx_nxt = blk_last_idx;
      status_nxt   = blk_status;
      s2_valid_nxt = 1'b1;
    end else if (out_xfer) begin
      if (out_last) begin
        s2_valid_nxt = 1'b0;
      end else begin
        words_nxt[0] = words_r[1];
        words_nxt[1] = words_r[2];
        words_nxt[2] = words_r[3];
        idx_nxt      = idx_r + 2'd1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    words_r    <= words_nxt;
    idx_r      <= idx_nxt;
    last_idx_r <= last_idx_nxt;
    status_r   <= status_nxt;
  end

  // result channel
  assign out_rsp.valid      = s2_valid_r;
  assign out_rsp.block_word = words_r[0];
  assign out_rsp.word_index = idx_r;
  assign out_rsp.last_word  = out_last;
  assign out_rsp.status     = status_r;

  // checks
  `PBF_ASSERT_SAME(a_err_single, clk, rst_n, s2_valid_r && (status_r == pbf_pkg::STATUS_ERR), out_last && (idx_r == pbf_pkg::LAST_IDX_SINGLE))
  `PBF_ASSERT_SAME(a_last_idx, clk, rst_n, s2_valid_r, (last_idx_r == pbf_pkg::LAST_IDX_SINGLE) || (last_idx_r == pbf_pkg::LAST_IDX_FMT4))
  `PBF_ASSERT_NEXT(a_idx_step, clk, rst_n, out_xfer && !out_last, s2_valid_r && (idx_r == $past(idx_r) + 2'd1))
  `PBF_ASSERT_SAME(a_stall_full, clk, rst_n, !in_req.ready, s1_valid_r && s2_valid_r)

endmodule

`default_nettype wire
